// ----- sv/mpr_pkg.sv -----
// Package for the MIDI packet router: port codes, status constants,
// copy descriptor types shared by the front end, queue and back end.
// No dependencies.
package mpr_pkg;

  // Port codes: core at 0, links 0..3 at 1..4.
  localparam logic [2:0] PortCore  = 3'd0;
  localparam logic [2:0] PortLink0 = 3'd1;
  localparam logic [2:0] PortLink1 = 3'd2;
  localparam logic [2:0] PortLink2 = 3'd3;
  localparam logic [2:0] PortLink3 = 3'd4;
  localparam logic [2:0] LockNone  = 3'd5;

  // Status and type constants.
  localparam logic [7:0] StClockLo     = 8'hF8;
  localparam logic [7:0] StClockHi     = 8'hFC;
  localparam logic [7:0] StActiveSense = 8'hFE;
  localparam logic [7:0] SplitNote     = 8'h3C;
  localparam logic [7:0] TransposeAmt  = 8'd24;
  localparam logic [3:0] TypeSysex     = 4'h4;
  localparam logic [3:0] TypeNoteOff   = 4'h8;
  localparam logic [3:0] TypeNoteOn    = 4'h9;
  localparam logic [3:0] TypeChanLo    = 4'h8;
  localparam logic [3:0] TypeChanHi    = 4'hE;
  localparam logic [3:0] ChanHighest   = 4'hF;
  localparam logic [3:0] ChanLowSplit  = 4'd9;
  localparam logic [3:0] ChanTranspose = 4'd1;
  localparam logic [3:0] ChanHighSplit = 4'd13;

  // Copies per packet and default queue depth.
  localparam int MaxCopies  = 5;
  localparam int QueueDepth = 4;

  // Rewrite applied to one copy.
  typedef enum logic [1:0] {
    MOD_NONE,
    MOD_CH_LOW,
    MOD_CH_TRANSPOSE,
    MOD_CH_HIGH
  } mod_t;

  typedef struct packed {
    logic [2:0] dest;
    mod_t       mod;
  } slot_t;

  // One classified packet: list of copies plus the packet bytes.
  typedef struct packed {
    logic [2:0]                 count;
    slot_t [MaxCopies-1:0]      slots;
    logic [3:0]                 ptype;
    logic [7:0]                 status;
    logic [7:0]                 data1;
    logic [7:0]                 data2;
    logic [2:0]                 lock;
  } desc_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic slot_t mk_slot(logic [2:0] dest, mod_t mod);
    slot_t s;
    s.dest = dest;
    s.mod  = mod;
    return s;
  endfunction

endpackage

// ----- sv/mpr_front.sv -----
// Front end of the MIDI packet router: accepts packets, keeps the SysEx
// lock and the split register, and classifies each packet into a copy list.
// Depends on mpr_pkg.
module mpr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_src_port,
  input  logic [3:0]        in_packet_type,
  input  logic [7:0]        in_status_byte,
  input  logic [7:0]        in_data_byte1,
  input  logic [7:0]        in_data_byte2,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_split_high_channels,
  input  mpr_pkg::q_status_t q_status,
  output logic              q_push,
  output mpr_pkg::desc_t    q_wdata
);
  import mpr_pkg::*;

  logic       split_r, split_nxt;
  logic [2:0] lock_r, lock_nxt;
  logic       accept;
  logic       port_ok;
  logic       clk_cls;
  logic       split_hit;
  logic       note_split;
  logic [2:0] n;
  logic [2:0] new_lock;
  desc_t      desc;

  // The queue is the only source of back pressure.
  assign in_stall  = q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Classification of the packet into its ordered list of copies.
  always_comb begin
    clk_cls    = (in_status_byte >= StClockLo) && (in_status_byte <= StClockHi);
    split_hit  = split_r && (in_packet_type >= TypeChanLo) &&
                 (in_packet_type <= TypeChanHi) && in_status_byte[3];
    note_split = ((in_packet_type == TypeNoteOff) || (in_packet_type == TypeNoteOn)) &&
                 (in_status_byte[3:0] == ChanHighest);
    new_lock   = (in_packet_type == TypeSysex) ? in_src_port : LockNone;
    desc       = '0;
    n          = 3'd0;
    port_ok    = 1'b1;
    unique case (in_src_port)
      PortCore: begin
        for (int i = 0; i < 4; i++) begin
          desc.slots[n] = mk_slot(3'(i + 1), MOD_NONE);
          n = n + 3'd1;
        end
      end
      PortLink0, PortLink1: begin
        desc.slots[n] = mk_slot(PortCore, MOD_NONE);
        n = n + 3'd1;
      end
      PortLink2: begin
        if (clk_cls) begin
          for (int i = 0; i < 4; i++) begin
            desc.slots[n] = mk_slot(3'(i + 1), MOD_NONE);
            n = n + 3'd1;
          end
        end
        if (split_hit) begin
          if (!clk_cls) begin
            desc.slots[n] = mk_slot(PortLink0, MOD_NONE);
            n = n + 3'd1;
            desc.slots[n] = mk_slot(PortLink1, MOD_NONE);
            n = n + 3'd1;
          end
        end else begin
          desc.slots[n] = mk_slot(PortCore, MOD_NONE);
          n = n + 3'd1;
        end
      end
      PortLink3: begin
        if (in_status_byte != StClockLo) begin
          if (note_split) begin
            if (in_data_byte1 < SplitNote) begin
              desc.slots[n] = mk_slot(PortLink0, MOD_CH_LOW);
              n = n + 3'd1;
              desc.slots[n] = mk_slot(PortLink2, MOD_CH_TRANSPOSE);
              n = n + 3'd1;
            end else begin
              desc.slots[n] = mk_slot(PortLink1, MOD_CH_HIGH);
              n = n + 3'd1;
            end
          end
          if (in_status_byte != StActiveSense) begin
            desc.slots[n] = mk_slot(PortCore, MOD_NONE);
            n = n + 3'd1;
          end
        end
      end
      default: begin
        port_ok = 1'b0;
      end
    endcase
    desc.count  = n;
    desc.ptype  = in_packet_type;
    desc.status = in_status_byte;
    desc.data1  = in_data_byte1;
    desc.data2  = in_data_byte2;
    desc.lock   = new_lock;
  end

  // Packets with no copies still move the lock but skip the queue.
  assign q_push  = accept && port_ok && (n != 3'd0);
  assign q_wdata = desc;

  // Lock and split register updates.
  always_comb begin
    lock_nxt  = lock_r;
    split_nxt = split_r;
    if (accept && port_ok) begin
      lock_nxt = new_lock;
    end
    if (cfg_valid && cfg_ready) begin
      split_nxt = cfg_split_high_channels;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r  <= LockNone;
      split_r <= 1'b0;
    end else begin
      lock_r  <= lock_nxt;
      split_r <= split_nxt;
    end
  end

endmodule

// ----- sv/mpr_queue.sv -----
// Short descriptor queue between the router front end and back end.
// Register based, one write and one read port. Depends on mpr_pkg.
module mpr_queue #(
  parameter int DEPTH = mpr_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mpr_pkg::desc_t     wdata,
  input  logic               pop,
  output mpr_pkg::desc_t     rdata,
  output mpr_pkg::q_status_t status
);
  import mpr_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  desc_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (cnt_r == CntFull);
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/mpr_back.sv -----
// Back end of the MIDI packet router: walks the copy list of the head
// descriptor, applies rewrites and drives the output register. Depends on mpr_pkg.
module mpr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mpr_pkg::desc_t     q_rdata,
  input  mpr_pkg::q_status_t q_status,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_dest_port,
  output logic [3:0]         out_type,
  output logic [7:0]         out_status,
  output logic [7:0]         out_data1,
  output logic [7:0]         out_data2,
  output logic               out_last_of_run,
  output logic [2:0]         out_lock_owner
);
  import mpr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] dest_r, type_dummy;
  logic [3:0] type_r;
  logic [7:0] status_r, data1_r, data2_r;
  logic       last_r;
  logic [2:0] lock_r;
  logic       load;
  logic       emit;
  logic       is_last;
  slot_t      cur;
  logic [7:0] status_nxt;
  logic [7:0] data1_nxt;

  assign type_dummy = q_rdata.lock;
  assign load    = !valid_r || !out_stall;
  assign emit    = load && !q_status.empty;
  assign cur     = q_rdata.slots[idx_r];
  assign is_last = (idx_r == (q_rdata.count - 3'd1));
  assign q_pop   = emit && is_last;

  // Channel rewrite and transpose for the current copy.
  always_comb begin
    status_nxt = q_rdata.status;
    data1_nxt  = q_rdata.data1;
    unique case (cur.mod)
      MOD_NONE: begin
      end
      MOD_CH_LOW: begin
        status_nxt = {q_rdata.status[7:4], ChanLowSplit};
      end
      MOD_CH_TRANSPOSE: begin
        status_nxt = {q_rdata.status[7:4], ChanTranspose};
        data1_nxt  = q_rdata.data1 + TransposeAmt;
      end
      MOD_CH_HIGH: begin
        status_nxt = {q_rdata.status[7:4], ChanHighSplit};
      end
      default: begin
      end
    endcase
  end

  // Copy index and output valid.
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = emit;
    end
    if (emit) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      dest_r   <= cur.dest;
      type_r   <= q_rdata.ptype;
      status_r <= status_nxt;
      data1_r  <= data1_nxt;
      data2_r  <= q_rdata.data2;
      last_r   <= is_last;
      lock_r   <= type_dummy;
    end
  end

  assign out_valid       = valid_r;
  assign out_dest_port   = dest_r;
  assign out_type        = type_r;
  assign out_status      = status_r;
  assign out_data1       = data1_r;
  assign out_data2       = data2_r;
  assign out_last_of_run = last_r;
  assign out_lock_owner  = lock_r;

endmodule

// ----- sv/midi_packet_router_core.sv -----
// MIDI packet router top level. An accepted packet beat is written into the queue,
// and each copy then passes through the back end output register. Throughput: one
// result beat per cycle while out_stall is low; a packet gives 1 to 5 copies, one beat
// each, and packets that give no copies never enter the queue. The queue lets the
// input keep flowing while results stall. Reset clears the queue, the output
// register, the SysEx lock (to no owner) and the split register (to 0).
module midi_packet_router_core #(
  parameter int QUEUE_DEPTH = mpr_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_src_port,
  input  logic [3:0] in_packet_type,
  input  logic [7:0] in_status_byte,
  input  logic [7:0] in_data_byte1,
  input  logic [7:0] in_data_byte2,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_dest_port,
  output logic [3:0] out_type,
  output logic [7:0] out_status,
  output logic [7:0] out_data1,
  output logic [7:0] out_data2,
  output logic       out_last_of_run,
  output logic [2:0] out_lock_owner,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_split_high_channels
);
  import mpr_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  desc_t     q_wdata;
  desc_t     q_rdata;

  // Front end: classification and lock.
  mpr_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_src_port             (in_src_port),
    .in_packet_type          (in_packet_type),
    .in_status_byte          (in_status_byte),
    .in_data_byte1           (in_data_byte1),
    .in_data_byte2           (in_data_byte2),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_split_high_channels (cfg_split_high_channels),
    .q_status                (q_status),
    .q_push                  (q_push),
    .q_wdata                 (q_wdata)
  );

  // Descriptor queue.
  mpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // Back end: copy sequencer and output register.
  mpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_port   (out_dest_port),
    .out_type        (out_type),
    .out_status      (out_status),
    .out_data1       (out_data1),
    .out_data2       (out_data2),
    .out_last_of_run (out_last_of_run),
    .out_lock_owner  (out_lock_owner)
  );

  // A beat that is not the last of its packet is always followed by another.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("copy run ended without a last beat");

  // Results only ever go to one of the five real ports.
  a_dest_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dest_port <= PortLink3)
    else $error("result routed to a nonexistent port");

  // The input only stalls when the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_status.full)
    else $error("input stalled while queue has room");

endmodule

// ----- sim/tb_midi_packet_router_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for midi_packet_router_core: routed copies of MIDI packets.
// Depends on mpr_pkg and the midi_packet_router_core RTL only.
module tb_midi_packet_router_core;
  import mpr_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 8;
  localparam int PhaseItems    = 22;

  // One incoming packet beat.
  typedef struct packed {
    logic [2:0] src;
    logic [3:0] ptype;
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
  } midi_pkt_t;

  // One routed copy as it should leave the block.
  typedef struct packed {
    logic [2:0] dest;
    logic [3:0] ptype;
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
    logic       last;
    logic [2:0] lock;
  } route_t;

  typedef enum int {
    KIND_CHANNEL,
    KIND_NOTE_CH16,
    KIND_CLOCK,
    KIND_SENSE,
    KIND_SYSEX,
    KIND_BAD_PORT,
    KIND_RAW
  } pkt_kind_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_src_port;
  logic [3:0] in_packet_type;
  logic [7:0] in_status_byte;
  logic [7:0] in_data_byte1;
  logic [7:0] in_data_byte2;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_dest_port;
  logic [3:0] out_type;
  logic [7:0] out_status;
  logic [7:0] out_data1;
  logic [7:0] out_data2;
  logic       out_last_of_run;
  logic [2:0] out_lock_owner;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_split_high_channels;

  midi_pkt_t  pending_pkts[$];
  route_t     expected_routes[$];
  logic [2:0] lock_shadow;
  logic       split_shadow;
  logic       in_took;
  int         send_idle_pct;
  int         stall_pct;
  int         error_count;
  int         quiet_cycles;

  midi_packet_router_core uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_src_port             (in_src_port),
    .in_packet_type          (in_packet_type),
    .in_status_byte          (in_status_byte),
    .in_data_byte1           (in_data_byte1),
    .in_data_byte2           (in_data_byte2),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_dest_port           (out_dest_port),
    .out_type                (out_type),
    .out_status              (out_status),
    .out_data1               (out_data1),
    .out_data2               (out_data2),
    .out_last_of_run         (out_last_of_run),
    .out_lock_owner          (out_lock_owner),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_split_high_channels (cfg_split_high_channels)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic midi_pkt_t make_pkt(logic [2:0] src, logic [3:0] ptype,
                                         logic [7:0] status, logic [7:0] data1,
                                         logic [7:0] data2);
    midi_pkt_t p;
    p.src    = src;
    p.ptype  = ptype;
    p.status = status;
    p.data1  = data1;
    p.data2  = data2;
    return p;
  endfunction

  function automatic route_t make_copy(midi_pkt_t p, logic [2:0] dest,
                                       logic [7:0] status, logic [7:0] data1);
    route_t r;
    r.dest   = dest;
    r.ptype  = p.ptype;
    r.status = status;
    r.data1  = data1;
    r.data2  = p.data2;
    r.last   = 1'b0;
    r.lock   = lock_shadow;
    return r;
  endfunction

  // Works out the copies of one accepted packet and queues them in order.
  task automatic route_packet(input midi_pkt_t p);
    route_t     copies[$];
    logic       is_clock;
    logic       is_split;
    logic       is_ch16_note;
    logic [7:0] hi_nib;
    if (p.src > PortLink3) return;
    lock_shadow  = (p.ptype == TypeSysex) ? p.src : LockNone;
    hi_nib       = {p.status[7:4], 4'h0};
    is_clock     = (p.status >= StClockLo) && (p.status <= StClockHi);
    is_split     = split_shadow && (p.ptype >= TypeChanLo) && (p.ptype <= TypeChanHi) &&
                   (p.status[3:0] >= 4'd8);
    is_ch16_note = ((p.ptype == TypeNoteOff) || (p.ptype == TypeNoteOn)) &&
                   (p.status[3:0] == ChanHighest);
    case (p.src)
      PortCore: begin
        for (int d = PortLink0; d <= PortLink3; d++)
          copies.push_back(make_copy(p, 3'(d), p.status, p.data1));
      end
      PortLink0, PortLink1: begin
        copies.push_back(make_copy(p, PortCore, p.status, p.data1));
      end
      PortLink2: begin
        // Clock bytes go to every link; split copies are then already covered.
        if (is_clock)
          for (int d = PortLink0; d <= PortLink3; d++)
            copies.push_back(make_copy(p, 3'(d), p.status, p.data1));
        if (is_split) begin
          if (!is_clock) begin
            copies.push_back(make_copy(p, PortLink0, p.status, p.data1));
            copies.push_back(make_copy(p, PortLink1, p.status, p.data1));
          end
        end else begin
          copies.push_back(make_copy(p, PortCore, p.status, p.data1));
        end
      end
      default: begin
        // Link 3: timing clock is dropped, channel 16 notes are split at middle C.
        if (p.status == StClockLo) return;
        if (is_ch16_note) begin
          if (p.data1 < SplitNote) begin
            copies.push_back(make_copy(p, PortLink0, hi_nib | ChanLowSplit, p.data1));
            copies.push_back(make_copy(p, PortLink2, hi_nib | ChanTranspose,
                                       p.data1 + TransposeAmt));
          end else begin
            copies.push_back(make_copy(p, PortLink1, hi_nib | ChanHighSplit, p.data1));
          end
        end
        if (p.status != StActiveSense)
          copies.push_back(make_copy(p, PortCore, p.status, p.data1));
      end
    endcase
    if (copies.size() != 0) copies[copies.size() - 1].last = 1'b1;
    foreach (copies[i]) expected_routes.push_back(copies[i]);
  endtask

  // Mostly well-formed MIDI traffic with random content, plus some noise.
  function automatic midi_pkt_t random_packet();
    midi_pkt_t p;
    pkt_kind_t kind;
    kind     = pkt_kind_t'($urandom_range(KIND_CHANNEL, KIND_RAW));
    p.src    = 3'($urandom_range(PortCore, PortLink3));
    p.ptype  = 4'($urandom);
    p.status = 8'($urandom);
    p.data1  = 8'($urandom);
    p.data2  = 8'($urandom);
    case (kind)
      KIND_CHANNEL: begin
        p.ptype    = 4'($urandom_range(TypeChanLo, TypeChanHi));
        p.status   = {p.ptype, 4'($urandom)};
        p.data1[7] = 1'b0;
      end
      KIND_NOTE_CH16: begin
        if ($urandom_range(0, 3) != 0) p.src = PortLink3;
        p.ptype  = $urandom_range(0, 1) ? TypeNoteOn : TypeNoteOff;
        p.status = {p.ptype, ChanHighest};
        p.data1  = 8'($urandom_range(SplitNote - 12, SplitNote + 12));
      end
      KIND_CLOCK: begin
        if ($urandom_range(0, 1) != 0) p.src = PortLink2;
        p.status = 8'($urandom_range(StClockLo, StClockHi));
      end
      KIND_SENSE: p.status = StActiveSense;
      KIND_SYSEX: p.ptype = TypeSysex;
      KIND_BAD_PORT: p.src = 3'($urandom_range(LockNone, 7));
      default: ;
    endcase
    return p;
  endfunction

  // Input side: record each accepted beat and predict its copies.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      route_packet(pending_pkts.pop_front());
    end
  end

  // Input driver: present the oldest pending packet, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (pending_pkts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid       <= 1'b1;
      in_src_port    <= pending_pkts[0].src;
      in_packet_type <= pending_pkts[0].ptype;
      in_status_byte <= pending_pkts[0].status;
      in_data_byte1  <= pending_pkts[0].data1;
      in_data_byte2  <= pending_pkts[0].data2;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endfunction

  // Result monitor: compare each beat against the oldest predicted copy.
  always @(posedge clk) begin
    route_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_routes.size() == 0) begin
        $error("out beat with no copy expected: dest %0d status %0h", out_dest_port,
               out_status);
        error_count++;
      end else begin
        r = expected_routes.pop_front();
        check_field("out_dest_port", r.dest, out_dest_port);
        check_field("out_type", r.ptype, out_type);
        check_field("out_status", r.status, out_status);
        check_field("out_data1", r.data1, out_data1);
        check_field("out_data2", r.data2, out_data2);
        check_field("out_last_of_run", r.last, out_last_of_run);
        check_field("out_lock_owner", r.lock, out_lock_owner);
      end
    end
  end

  // Watchdog on cycles where no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("midi_packet_router_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every packet is taken and every copy seen, then let the block settle.
  task automatic wait_drained();
    while (pending_pkts.size() != 0 || expected_routes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_split(input logic value);
    @(negedge clk);
    cfg_valid               <= 1'b1;
    cfg_split_high_channels <= value;
    do @(posedge clk); while (!cfg_ready);
    split_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    in_valid                = 1'b0;
    in_src_port             = '0;
    in_packet_type          = '0;
    in_status_byte          = '0;
    in_data_byte1           = '0;
    in_data_byte2           = '0;
    out_stall               = 1'b0;
    cfg_valid               = 1'b0;
    cfg_split_high_channels = 1'b0;
    in_took                 = 1'b0;
    lock_shadow             = LockNone;
    split_shadow            = 1'b0;
    send_idle_pct           = 0;
    stall_pct               = 0;
    error_count             = 0;
    quiet_cycles            = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed packets with high-channel split off.
    write_split(1'b0);
    pending_pkts.push_back(make_pkt(PortCore, 4'hF, 8'hFF, 8'hFF, 8'hFF));
    pending_pkts.push_back(make_pkt(PortCore, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink0, TypeSysex, 8'hF0, 8'h7E, 8'h01));
    pending_pkts.push_back(make_pkt(PortLink1, TypeNoteOn, 8'h90, 8'h40, 8'h7F));
    pending_pkts.push_back(make_pkt(PortLink2, 4'hF, StClockLo, 8'h00, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink2, 4'hF, StClockHi, 8'h00, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink2, TypeNoteOn, 8'h9F, 8'h3C, 8'h40));
    pending_pkts.push_back(make_pkt(PortLink3, 4'hF, StClockLo, 8'h00, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink3, TypeNoteOn, 8'h9F, 8'h3B, 8'h64));
    pending_pkts.push_back(make_pkt(PortLink3, TypeNoteOff, 8'h8F, SplitNote, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink3, TypeNoteOn, 8'h9F, 8'h00, 8'h7F));
    pending_pkts.push_back(make_pkt(PortLink3, 4'hF, StActiveSense, 8'h00, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink3, TypeSysex, 8'hF0, 8'h12, 8'h34));
    pending_pkts.push_back(make_pkt(3'd5, TypeSysex, 8'hF0, 8'hAA, 8'h55));
    pending_pkts.push_back(make_pkt(3'd7, 4'hF, 8'hFF, 8'hFF, 8'hFF));
    pending_pkts.push_back(make_pkt(PortLink3, TypeNoteOn, 8'h9F, 8'hFF, 8'hFF));
    wait_drained();

    // Directed packets with high-channel split on.
    write_split(1'b1);
    pending_pkts.push_back(make_pkt(PortLink2, TypeNoteOn, 8'h98, 8'h30, 8'h50));
    pending_pkts.push_back(make_pkt(PortLink2, TypeChanHi, 8'hEF, 8'h00, 8'h40));
    pending_pkts.push_back(make_pkt(PortLink2, TypeNoteOff, 8'h87, 8'h30, 8'h00));
    pending_pkts.push_back(make_pkt(PortLink2, TypeNoteOff, StClockLo, 8'h01, 8'h02));
    pending_pkts.push_back(make_pkt(PortLink2, TypeChanHi, StClockHi, 8'h03, 8'h04));
    pending_pkts.push_back(make_pkt(PortLink2, 4'hF, 8'hFF, 8'h05, 8'h06));
    pending_pkts.push_back(make_pkt(PortLink2, 4'h7, 8'h9A, 8'h07, 8'h08));
    pending_pkts.push_back(make_pkt(PortLink2, TypeSysex, 8'hF0, 8'h09, 8'h0A));
    wait_drained();

    // Random traffic under each idling pattern, alternating the split setting.
    for (int ph = 0; ph < 4; ph++) begin
      write_split(ph % 2 != 0);
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < PhaseItems; n++) pending_pkts.push_back(random_packet());
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
    end

    if (error_count == 0) begin
      $display("midi_packet_router_core test passed");
    end else begin
      $display("midi_packet_router_core test failed");
    end
    $finish;
  end

endmodule
